>>> hdl/progression_intersect_core_macros.svh
// Assertion macros for the progression intersection core.
`ifndef PROGRESSION_INTERSECT_CORE_MACROS_SVH
`define PROGRESSION_INTERSECT_CORE_MACROS_SVH
`ifndef SYNTH
// Check that the antecedent implies the consequent in the same cycle.
`define PIC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("progression intersect check failed");
// Check that the antecedent implies the consequent in the next cycle.
`define PIC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("progression intersect check failed");
`else
`define PIC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PIC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/pic_pkg.sv
// Shared types, width helpers and defaults for the progression intersection core.
`default_nettype none
package pic_pkg;

   localparam int START_WIDTH_DEF = 32;
   localparam int STEP_WIDTH_DEF  = 16;
   localparam int COUNT_WIDTH_DEF = 24;

   // Width of the result start field
   function automatic int meet_start_w(input int sw, input int dw, input int cw);
      return ((sw > dw + cw) ? sw : dw + cw) + 2;
   endfunction

   // Width of the internal signed working values
   function automatic int work_w(input int sw, input int dw, input int cw);
      int a;
      int b;
      a = meet_start_w(sw, dw, cw) + 2;
      b = 2 * dw + 2;
      return (a > b) ? a : b;
   endfunction

   // Round a width up to whole bytes
   function automatic int pad8(input int n);
      return ((n + 7) / 8) * 8;
   endfunction

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_A, OP_MUL_B, OP_ADD_B,
      OP_EU_DIV, OP_EU_MUL, OP_EU_UPD, OP_G_DIV, OP_G_CHK,
      OP_M_DIV, OP_M_SET, OP_K_DIV, OP_K_MUL, OP_P_DIV,
      OP_X_MUL, OP_X_ADD, OP_L_DIV, OP_S_SET, OP_C_DIV,
      OP_EMIT, OP_EMIT_ZERO
   } pic_op_type;

   typedef struct packed {
      pic_op_type op;
   } pic_cmd_type;

   typedef struct packed {
      logic win_bad;
      logic r1_zero;
      logic div_done;
      logic g_bad;
      logic start_bad;
   } pic_stat_type;

endpackage
`default_nettype wire

>>> hdl/pic_div.sv
// Bit-serial restoring divider shared by all division steps of the intersection.
`default_nettype none
module pic_div #(
   parameter int W       = 44,
   parameter int LW      = 32,
   parameter int SHORT_W = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          short_mode,
   input  wire logic [W-1:0]  dvd,
   input  wire logic [LW-1:0] dvs,
   output logic               done,
   output logic [W-1:0]       quo,
   output logic [LW-1:0]      rem,
   output logic [LW-1:0]      dvs_q
);
   localparam int CNTW = $clog2(W + 1);

   logic [W-1:0]    quo_ff, quo_in;
   logic [LW-1:0]   rem_ff, rem_in;
   logic [LW-1:0]   dvs_ff, dvs_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [LW:0]     rem_sh;
   logic            ge;

   // One quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = short_mode ? (dvd << (W - SHORT_W)) : dvd;
         rem_in  = '0;
         dvs_in  = dvs;
         cnt_in  = short_mode ? CNTW'(SHORT_W) : CNTW'(W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? LW'(rem_sh - {1'b0, dvs_ff}) : LW'(rem_sh);
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign quo   = quo_ff;
   assign rem   = rem_ff;
   assign dvs_q = dvs_ff;
endmodule
`default_nettype wire

>>> hdl/pic_dp.sv
// Datapath: operand registers, multipliers, window logic and the shared divider.
`default_nettype none
module pic_dp #(
   parameter int SW = 32,
   parameter int DW = 16,
   parameter int CW = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pic_pkg::pic_cmd_type  cmd,
   input  wire logic [SW-1:0]         first_start,
   input  wire logic [DW-1:0]         first_step,
   input  wire logic [CW-1:0]         first_count,
   input  wire logic [SW-1:0]         second_start,
   input  wire logic [DW-1:0]         second_step,
   input  wire logic [CW-1:0]         second_count,
   output pic_pkg::pic_stat_type      stat,
   output logic [pic_pkg::meet_start_w(SW, DW, CW)-1:0] meet_start,
   output logic [2*DW-1:0]            meet_step,
   output logic [CW-1:0]              meet_count
);
   import pic_pkg::*;

   localparam int MSW = meet_start_w(SW, DW, CW);
   localparam int LW  = 2 * DW;
   localparam int W   = work_w(SW, DW, CW);

   logic [SW-1:0]        sa_ff, sb_ff;
   logic [DW-1:0]        da_ff, db_ff, r0_ff, r1_ff, m_ff;
   logic [CW-1:0]        ca_ff, cb_ff;
   logic [W-1:0]         prod_ff;
   logic signed [W-1:0]  last_a_ff, last_b_ff, diffq_ff, x0_ff, start_ff;
   logic signed [DW+1:0] s0_ff, s1_ff, qs_ff;
   logic [LW-1:0]        lcm_ff;
   logic                 neg_ff;
   logic [MSW-1:0]       mstart_ff;
   logic [LW-1:0]        mstep_ff;
   logic [CW-1:0]        mcount_ff;

   logic signed [W-1:0]  sa_w, sb_w, lo_c, hi_c, sval, qf;
   logic [W-1:0]         mag;
   logic [LW-1:0]        dvs_sel, re;
   logic                 div_start, div_short, div_done, rnz;
   logic [W-1:0]         div_q;
   logic [LW-1:0]        div_r, div_dvs;
   logic [CW-1:0]        cam1, cbm1;
   logic [DW+CW-1:0]     mul_a, mul_b;
   logic signed [2*DW+2:0] qs_full;
   logic signed [DW+1:0] m_s, pe_a, pe_b;
   logic [LW-1:0]        mul_lcm, mul_k, mul_x;

   // Window bounds and sign-extended starts
   always_comb begin
      sa_w = W'($signed(sa_ff));
      sb_w = W'($signed(sb_ff));
      lo_c = (sa_w > sb_w) ? sa_w : sb_w;
      hi_c = (last_a_ff < last_b_ff) ? last_a_ff : last_b_ff;
   end

   // Select divider operands for the current step
   always_comb begin
      sval      = '0;
      dvs_sel   = LW'(r1_ff);
      div_start = 1'b1;
      div_short = 1'b0;
      unique case (cmd.op)
         OP_EU_DIV: begin
            sval      = W'(r0_ff);
            dvs_sel   = LW'(r1_ff);
            div_short = 1'b1;
         end
         OP_G_DIV: begin
            sval    = sb_w - sa_w;
            dvs_sel = LW'(r0_ff);
         end
         OP_M_DIV: begin
            sval    = W'(db_ff);
            dvs_sel = LW'(r0_ff);
         end
         OP_K_DIV: begin
            sval    = diffq_ff;
            dvs_sel = LW'(m_ff);
         end
         OP_P_DIV: begin
            sval    = $signed(prod_ff);
            dvs_sel = LW'(m_ff);
         end
         OP_L_DIV: begin
            sval    = x0_ff - lo_c;
            dvs_sel = lcm_ff;
         end
         OP_C_DIV: begin
            sval    = hi_c - start_ff;
            dvs_sel = lcm_ff;
         end
         default: div_start = 1'b0;
      endcase
      mag = (sval < 0) ? W'(-sval) : W'(sval);
   end

   pic_div #(.W(W), .LW(LW), .SHORT_W(DW)) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .short_mode (div_short),
      .dvd        (mag),
      .dvs        (dvs_sel),
      .done       (div_done),
      .quo        (div_q),
      .rem        (div_r),
      .dvs_q      (div_dvs)
   );

   // Turn the unsigned quotient and remainder into floor and Euclidean form
   always_comb begin
      rnz = div_r != '0;
      qf  = neg_ff ? (-$signed(div_q) - W'(rnz)) : $signed(div_q);
      re  = (neg_ff && rnz) ? (div_dvs - div_r) : div_r;
   end

   // Multipliers and the Bezout coefficient reduced modulo m
   always_comb begin
      cam1    = ca_ff - 1'b1;
      cbm1    = cb_ff - 1'b1;
      mul_a   = da_ff * cam1;
      mul_b   = db_ff * cbm1;
      qs_full = $signed({1'b0, div_q[DW-1:0]}) * s1_ff;
      mul_lcm = da_ff * div_q[DW-1:0];
      m_s     = $signed((DW+2)'(m_ff));
      pe_a    = (s0_ff < 0) ? (s0_ff + m_s) : s0_ff;
      pe_b    = (pe_a >= m_s) ? (pe_a - m_s) : pe_a;
      mul_k   = re[DW-1:0] * pe_b[DW-1:0];
      mul_x   = da_ff * div_r[DW-1:0];
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      if (div_start) begin
         neg_ff <= sval < 0;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            sa_ff <= first_start;
            da_ff <= first_step;
            ca_ff <= first_count;
            sb_ff <= second_start;
            db_ff <= second_step;
            cb_ff <= second_count;
            r0_ff <= first_step;
            r1_ff <= second_step;
            s0_ff <= (DW+2)'(1);
            s1_ff <= '0;
         end
         OP_MUL_A: prod_ff <= W'(mul_a);
         OP_MUL_B: begin
            last_a_ff <= sa_w + $signed(prod_ff);
            prod_ff   <= W'(mul_b);
         end
         OP_ADD_B: last_b_ff <= sb_w + $signed(prod_ff);
         OP_EU_MUL: begin
            qs_ff <= qs_full[DW+1:0];
            r0_ff <= r1_ff;
            r1_ff <= div_r[DW-1:0];
         end
         OP_EU_UPD: begin
            s0_ff <= s1_ff;
            s1_ff <= s0_ff - qs_ff;
         end
         OP_G_CHK: diffq_ff <= qf;
         OP_M_SET: begin
            m_ff   <= div_q[DW-1:0];
            lcm_ff <= mul_lcm;
         end
         OP_K_MUL: prod_ff <= W'(mul_k);
         OP_X_MUL: prod_ff <= W'(mul_x);
         OP_X_ADD: x0_ff <= sa_w + $signed(prod_ff);
         OP_S_SET: start_ff <= lo_c + $signed(W'(re));
         OP_EMIT: begin
            mstart_ff <= start_ff[MSW-1:0];
            mstep_ff  <= lcm_ff;
            mcount_ff <= div_q[CW-1:0] + 1'b1;
         end
         OP_EMIT_ZERO: begin
            mstart_ff <= '0;
            mstep_ff  <= '0;
            mcount_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   // Report status to the controller
   always_comb begin
      stat.win_bad   = (ca_ff == '0) || (cb_ff == '0) || (da_ff == '0) ||
                       (db_ff == '0) || (lo_c > hi_c);
      stat.r1_zero   = r1_ff == '0;
      stat.div_done  = div_done;
      stat.g_bad     = re != '0;
      stat.start_bad = start_ff > hi_c;
   end

   assign meet_start = mstart_ff;
   assign meet_step  = mstep_ff;
   assign meet_count = mcount_ff;
endmodule
`default_nettype wire

>>> hdl/pic_ctrl.sv
// Controller: sequences the datapath and runs both stream handshakes.
`default_nettype none
module pic_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire pic_pkg::pic_stat_type stat,
   output pic_pkg::pic_cmd_type       cmd
);
   import pic_pkg::*;

   typedef enum logic [29:0] {
      ST_IDLE    = 30'd1 << 0,
      ST_MUL_A   = 30'd1 << 1,
      ST_MUL_B   = 30'd1 << 2,
      ST_ADD_B   = 30'd1 << 3,
      ST_WIN     = 30'd1 << 4,
      ST_EU_DIV  = 30'd1 << 5,
      ST_EU_WAIT = 30'd1 << 6,
      ST_EU_MUL  = 30'd1 << 7,
      ST_EU_UPD  = 30'd1 << 8,
      ST_G_DIV   = 30'd1 << 9,
      ST_G_WAIT  = 30'd1 << 10,
      ST_G_CHK   = 30'd1 << 11,
      ST_M_DIV   = 30'd1 << 12,
      ST_M_WAIT  = 30'd1 << 13,
      ST_M_SET   = 30'd1 << 14,
      ST_K_DIV   = 30'd1 << 15,
      ST_K_WAIT  = 30'd1 << 16,
      ST_K_MUL   = 30'd1 << 17,
      ST_P_DIV   = 30'd1 << 18,
      ST_P_WAIT  = 30'd1 << 19,
      ST_X_MUL   = 30'd1 << 20,
      ST_X_ADD   = 30'd1 << 21,
      ST_L_DIV   = 30'd1 << 22,
      ST_L_WAIT  = 30'd1 << 23,
      ST_S_SET   = 30'd1 << 24,
      ST_S_CHK   = 30'd1 << 25,
      ST_C_DIV   = 30'd1 << 26,
      ST_C_WAIT  = 30'd1 << 27,
      ST_EMIT    = 30'd1 << 28,
      ST_ZERO    = 30'd1 << 29
   } pic_state_type;

   pic_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free, accept;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && (state_ff == ST_IDLE);

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            cmd.op   = OP_LOAD;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.op   = OP_MUL_A;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.op   = OP_MUL_B;
            state_in = ST_ADD_B;
         end
         ST_ADD_B: begin
            cmd.op   = OP_ADD_B;
            state_in = ST_WIN;
         end
         ST_WIN: state_in = stat.win_bad ? ST_ZERO : ST_EU_DIV;
         ST_EU_DIV: begin
            cmd.op   = OP_EU_DIV;
            state_in = ST_EU_WAIT;
         end
         ST_EU_WAIT: if (stat.div_done) state_in = ST_EU_MUL;
         ST_EU_MUL: begin
            cmd.op   = OP_EU_MUL;
            state_in = ST_EU_UPD;
         end
         ST_EU_UPD: begin
            cmd.op   = OP_EU_UPD;
            state_in = stat.r1_zero ? ST_G_DIV : ST_EU_DIV;
         end
         ST_G_DIV: begin
            cmd.op   = OP_G_DIV;
            state_in = ST_G_WAIT;
         end
         ST_G_WAIT: if (stat.div_done) state_in = ST_G_CHK;
         ST_G_CHK: begin
            cmd.op   = OP_G_CHK;
            state_in = stat.g_bad ? ST_ZERO : ST_M_DIV;
         end
         ST_M_DIV: begin
            cmd.op   = OP_M_DIV;
            state_in = ST_M_WAIT;
         end
         ST_M_WAIT: if (stat.div_done) state_in = ST_M_SET;
         ST_M_SET: begin
            cmd.op   = OP_M_SET;
            state_in = ST_K_DIV;
         end
         ST_K_DIV: begin
            cmd.op   = OP_K_DIV;
            state_in = ST_K_WAIT;
         end
         ST_K_WAIT: if (stat.div_done) state_in = ST_K_MUL;
         ST_K_MUL: begin
            cmd.op   = OP_K_MUL;
            state_in = ST_P_DIV;
         end
         ST_P_DIV: begin
            cmd.op   = OP_P_DIV;
            state_in = ST_P_WAIT;
         end
         ST_P_WAIT: if (stat.div_done) state_in = ST_X_MUL;
         ST_X_MUL: begin
            cmd.op   = OP_X_MUL;
            state_in = ST_X_ADD;
         end
         ST_X_ADD: begin
            cmd.op   = OP_X_ADD;
            state_in = ST_L_DIV;
         end
         ST_L_DIV: begin
            cmd.op   = OP_L_DIV;
            state_in = ST_L_WAIT;
         end
         ST_L_WAIT: if (stat.div_done) state_in = ST_S_SET;
         ST_S_SET: begin
            cmd.op   = OP_S_SET;
            state_in = ST_S_CHK;
         end
         ST_S_CHK: state_in = stat.start_bad ? ST_ZERO : ST_C_DIV;
         ST_C_DIV: begin
            cmd.op   = OP_C_DIV;
            state_in = ST_C_WAIT;
         end
         ST_C_WAIT: if (stat.div_done) state_in = ST_EMIT;
         ST_EMIT: if (slot_free) begin
            cmd.op   = OP_EMIT;
            state_in = ST_IDLE;
         end
         ST_ZERO: if (slot_free) begin
            cmd.op   = OP_EMIT_ZERO;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result valid until it is taken
   always_comb begin
      if ((cmd.op == OP_EMIT) || (cmd.op == OP_EMIT_ZERO)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
endmodule
`default_nettype wire

>>> hdl/progression_intersect_core.sv
// Top level of the arithmetic progression intersection core.
`default_nettype none
`include "progression_intersect_core_macros.svh"
// Takes two progressions (start, step, count) per item and returns their
// intersection as one progression: first common value, lcm step and count,
// all zero when empty. One item is worked on at a time; the result sits in
// an output register so the next item can be accepted while it waits.
// An item with empty inputs or disjoint windows skips the divider and gets a zero
// result. Otherwise the time taken grows with the widths and with the number of
// Euclid iterations on the two steps, since a single bit-serial divider serves
// Euclid, the gcd check, the modular reductions and the final count.
module progression_intersect_core #(
   parameter int START_WIDTH = pic_pkg::START_WIDTH_DEF,
   parameter int STEP_WIDTH  = pic_pkg::STEP_WIDTH_DEF,
   parameter int COUNT_WIDTH = pic_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // first_start, first_step, first_count, second_start, second_step,
   // second_count
   input  wire logic [pic_pkg::pad8(2*(START_WIDTH+STEP_WIDTH+COUNT_WIDTH))-1:0]
                     req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // meet_start, meet_step, meet_count
   output logic [pic_pkg::pad8(pic_pkg::meet_start_w(START_WIDTH, STEP_WIDTH,
                 COUNT_WIDTH) + 2*STEP_WIDTH + COUNT_WIDTH)-1:0] rsp_tdata
);
   import pic_pkg::*;

   localparam int SW    = START_WIDTH;
   localparam int DW    = STEP_WIDTH;
   localparam int CW    = COUNT_WIDTH;
   localparam int MSW   = meet_start_w(SW, DW, CW);
   localparam int LW    = 2 * DW;
   localparam int OUT_W = MSW + LW + CW;
   localparam int OUT_P = pad8(OUT_W);

   logic [SW-1:0]  first_start, second_start;
   logic [DW-1:0]  first_step, second_step;
   logic [CW-1:0]  first_count, second_count;
   logic [MSW-1:0] meet_start;
   logic [LW-1:0]  meet_step;
   logic [CW-1:0]  meet_count;
   pic_cmd_type    cmd;
   pic_stat_type   stat;

   // Unpack the request item
   assign first_start  = req_tdata[SW-1:0];
   assign first_step   = req_tdata[SW+DW-1:SW];
   assign first_count  = req_tdata[SW+DW+CW-1:SW+DW];
   assign second_start = req_tdata[2*SW+DW+CW-1:SW+DW+CW];
   assign second_step  = req_tdata[2*SW+2*DW+CW-1:2*SW+DW+CW];
   assign second_count = req_tdata[2*SW+2*DW+2*CW-1:2*SW+2*DW+CW];

   pic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pic_dp #(.SW(SW), .DW(DW), .CW(CW)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .first_start  (first_start),
      .first_step   (first_step),
      .first_count  (first_count),
      .second_start (second_start),
      .second_step  (second_step),
      .second_count (second_count),
      .stat         (stat),
      .meet_start   (meet_start),
      .meet_step    (meet_step),
      .meet_count   (meet_count)
   );

   // Pack the result item
   assign rsp_tdata = OUT_P'({meet_count, meet_step, meet_start});

   `PIC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `PIC_ASSERT_IMP(a_empty_is_zero, clock, reset, rsp_tvalid && (meet_count == '0), (meet_step == '0) && (meet_start == '0))
   `PIC_ASSERT_IMP(a_hit_has_step, clock, reset, rsp_tvalid && (meet_count != '0), meet_step != '0)
endmodule
`default_nettype wire
